// ----- hw/rtl/life_like_automaton_engine_defines.svh -----
// Assertion macros shared by the life-like automaton engine RTL
`ifndef LIFE_LIKE_AUTOMATON_ENGINE_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define LLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define LLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lla_pkg.sv -----
// Package with constants, codes and types of the life-like automaton engine
`default_nettype none
package lla_pkg;
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 7;
  localparam int MASK_W   = 9;
  localparam int CNT_W    = 4;
  localparam int GEN_W    = 16;
  localparam int KIND_W   = 2;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  typedef logic [MAX_COLS-1:0] row_t;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_BIRTH   = 2'd2;
  localparam logic [1:0] REG_SURVIVE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_SEEK_GEN,
    ST_ALIGN,
    ST_GEN,
    ST_FINISH
  } lla_state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lla_in_if.sv -----
// Input item channel of the life-like automaton engine
`default_nettype none
interface lla_in_if;
  import lla_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row_index;
  logic                cell_in;
  logic [GEN_W-1:0]    generations;
  modport source (output valid, kind, col, row_index, cell_in, generations, input ready);
  modport sink   (input valid, kind, col, row_index, cell_in, generations, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lla_out_if.sv -----
// Result channel of the life-like automaton engine
`default_nettype none
interface lla_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic status;
  modport source (output valid, cell_out, status, input ready);
  modport sink   (input valid, cell_out, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lla_row_cell.sv -----
// One grid row held in the rotating chain of row cells
`default_nettype none
module lla_row_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire logic          load_en,
  input  wire lla_pkg::row_t shift_d,
  input  wire lla_pkg::row_t load_d,
  output lla_pkg::row_t      row_q
);
  import lla_pkg::*;

  row_t row_r;

  // Take a local update first, else the neighbor's row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (load_en) begin
      row_r <= load_d;
    end else if (shift_en) begin
      row_r <= shift_d;
    end
  end

  assign row_q = row_r;
endmodule
`default_nettype wire

// ----- hw/rtl/lla_row_rule.sv -----
// Next-generation value of one row from its own and its two neighbor rows
`default_nettype none
module lla_row_rule (
  input  wire lla_pkg::row_t            up_row,
  input  wire lla_pkg::row_t            mid_row,
  input  wire lla_pkg::row_t            dn_row,
  input  wire logic [lla_pkg::DIM_W-1:0]  used_cols,
  input  wire logic [lla_pkg::MASK_W-1:0] birth_mask,
  input  wire logic [lla_pkg::MASK_W-1:0] survive_mask,
  output lla_pkg::row_t                 new_row
);
  import lla_pkg::*;

  logic [COL_W-1:0] last_col;

  assign last_col = COL_W'(used_cols - DIM_W'(1));

  // Count eight wrapped neighbors per column and apply the rule
  always_comb begin
    logic [COL_W-1:0] wi;
    logic [COL_W-1:0] ei;
    logic [CNT_W-1:0] cnt;
    new_row = mid_row;
    for (int c = 0; c < MAX_COLS; c++) begin
      wi  = (c == 0) ? last_col : COL_W'(c - 1);
      ei  = (COL_W'(c) == last_col) ? '0 : COL_W'(c + 1);
      cnt = CNT_W'(up_row[wi]) + CNT_W'(up_row[c]) + CNT_W'(up_row[ei])
          + CNT_W'(mid_row[wi]) + CNT_W'(mid_row[ei])
          + CNT_W'(dn_row[wi]) + CNT_W'(dn_row[c]) + CNT_W'(dn_row[ei]);
      if (DIM_W'(c) < used_cols) begin
        new_row[c] = mid_row[c] ? survive_mask[cnt] : birth_mask[cnt];
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/life_like_automaton_engine.sv -----
// Top level of the life-like automaton engine: row chain, sequencer, APB registers
//
// Usage:
//   in_chan (valid/ready) takes an item: write cell, run generations or read cell.
//   out_chan (valid/ready) returns exactly one transaction per item: cell_out and
//   status (1 when the coordinate lies outside the configured grid).
//   APB registers: 0 grid_width, 1 grid_height, 2 birth_mask, 3 survive_mask;
//   write them only while the engine is idle.
//   The grid rows sit in a ring of row cells that rotates by one row per cycle
//   while an item seeks its row or runs. A write or read waits for its row to
//   reach the head of the ring before it is served. A run first rotates the last
//   used row to the head to save it, then on to row 0, then rotates the whole ring
//   once per generation, one row per cycle; it stops early once a generation changes nothing.
//   Zero generations or an outside coordinate answer without rotating the ring.
//   One item is in work at a time; the result register lets the next item be
//   accepted while a finished result waits on a stalled receiver.
//   Reset (rst_n low, synchronous) clears every cell and restores B3/S23 on
//   a 64 by 64 grid.
`default_nettype none
`include "life_like_automaton_engine_defines.svh"
module life_like_automaton_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lla_in_if.sink                           in_chan,
  lla_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lla_pkg::APB_AW-1:0]  paddr,
  input  wire logic [lla_pkg::APB_DW-1:0]  pwdata,
  output logic      [lla_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);
  import lla_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]  width_r, height_r;
  logic [MASK_W-1:0] birth_r, survive_r;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(MAX_COLS);
      height_r  <= DIM_W'(MAX_ROWS);
      birth_r   <= MASK_W'(8);
      survive_r <= MASK_W'(12);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:   width_r   <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  height_r  <= pwdata[DIM_W-1:0];
        REG_BIRTH:   birth_r   <= pwdata[MASK_W-1:0];
        REG_SURVIVE: survive_r <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:   prdata = APB_DW'(width_r);
      REG_HEIGHT:  prdata = APB_DW'(height_r);
      REG_BIRTH:   prdata = APB_DW'(birth_r);
      REG_SURVIVE: prdata = APB_DW'(survive_r);
      default:     prdata = '0;
    endcase
  end

  // Clamp the configured size into the grid
  logic [DIM_W-1:0] used_cols, used_rows;
  logic [ROW_W-1:0] last_row;

  assign used_cols = (width_r == '0) ? DIM_W'(1) :
                     (width_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_r;
  assign used_rows = (height_r == '0) ? DIM_W'(1) :
                     (height_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_r;
  assign last_row  = ROW_W'(used_rows - DIM_W'(1));

  // Ring of row cells
  row_t row_q [MAX_ROWS];
  row_t tail_d, row0_mod, new_row;
  logic shift_en, load_en;

  for (genvar j = 0; j < MAX_ROWS; j++) begin : g_cell
    row_t sd;
    if (j == MAX_ROWS - 1) begin : g_tail
      assign sd = tail_d;
    end else begin : g_mid
      assign sd = row_q[j+1];
    end
    lla_row_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .load_en  ((j == 0) && load_en),
      .shift_d  (sd),
      .load_d   (row0_mod),
      .row_q    (row_q[j])
    );
  end

  // Sequencer registers
  lla_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]  head_r, head_nxt;
  logic [ROW_W-1:0]  t_r, t_nxt;
  logic [GEN_W-1:0]  gens_r, gens_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              val_r, val_nxt;
  row_t              prev_r, prev_nxt;
  row_t              first_r, first_nxt;
  row_t              lastnew_r, lastnew_nxt;
  logic              chg_r, chg_nxt;
  logic              res_cell_r, res_cell_nxt;
  logic              res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r, out_cell_nxt;
  logic              out_stat_r, out_stat_nxt;

  logic in_fire, out_fire, in_area, row_chg, inside_in;
  row_t dn_row;

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign out_fire        = out_valid_r && out_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.cell_out = out_cell_r;
  assign out_chan.status = out_stat_r;

  assign inside_in = (DIM_W'(in_chan.col) < used_cols) &&
                     (DIM_W'(in_chan.row_index) < used_rows);
  assign in_area   = DIM_W'(t_r) < used_rows;

  always_comb begin
    row0_mod        = row_q[0];
    row0_mod[col_r] = val_r;
  end

  // Row below: wrap to the saved original first row at the last used row
  assign dn_row = (t_r == last_row) ? ((t_r == '0) ? row_q[0] : first_r) : row_q[1];

  lla_row_rule u_rule (
    .up_row       (prev_r),
    .mid_row      (row_q[0]),
    .dn_row       (dn_row),
    .used_cols    (used_cols),
    .birth_mask   (birth_r),
    .survive_mask (survive_r),
    .new_row      (new_row)
  );

  assign row_chg = in_area && (new_row != row_q[0]);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    t_nxt         = t_r;
    gens_nxt      = gens_r;
    kind_nxt      = kind_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    lastnew_nxt   = lastnew_r;
    chg_nxt       = chg_r;
    res_cell_nxt  = res_cell_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_cell_nxt  = out_cell_r;
    out_stat_nxt  = out_stat_r;
    shift_en      = 1'b0;
    load_en       = 1'b0;
    tail_d        = row_q[0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt     = in_chan.kind;
          col_nxt      = in_chan.col;
          row_nxt      = in_chan.row_index;
          val_nxt      = in_chan.cell_in;
          gens_nxt     = in_chan.generations;
          res_cell_nxt = 1'b0;
          res_stat_nxt = 1'b0;
          state_nxt    = ST_FINISH;
          if (in_chan.kind == KIND_WRITE || in_chan.kind == KIND_READ) begin
            if (inside_in) begin
              state_nxt = ST_SEEK;
            end else begin
              res_stat_nxt = 1'b1;
            end
          end else if (in_chan.kind == KIND_RUN) begin
            if (in_chan.generations != '0) begin
              state_nxt = ST_SEEK_GEN;
            end
          end
        end
      end
      ST_SEEK: begin
        if (head_r == row_r) begin
          if (kind_r == KIND_WRITE) begin
            load_en = 1'b1;
          end else begin
            res_cell_nxt = row_q[0][col_r];
          end
          state_nxt = ST_FINISH;
        end else begin
          shift_en = 1'b1;
          head_nxt = head_r + ROW_W'(1);
        end
      end
      ST_SEEK_GEN: begin
        // Rotate until the last used row is at the head and save it
        shift_en = 1'b1;
        head_nxt = head_r + ROW_W'(1);
        if (head_r == last_row) begin
          prev_nxt  = row_q[0];
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // Rotate on until row 0 is at the head, then start the pass
        if (head_r == '0) begin
          t_nxt     = '0;
          chg_nxt   = 1'b0;
          state_nxt = ST_GEN;
        end else begin
          shift_en = 1'b1;
          head_nxt = head_r + ROW_W'(1);
        end
      end
      ST_GEN: begin
        shift_en = 1'b1;
        head_nxt = head_r + ROW_W'(1);
        t_nxt    = t_r + ROW_W'(1);
        if (in_area) begin
          tail_d   = new_row;
          prev_nxt = row_q[0];
          if (t_r == '0) begin
            first_nxt = row_q[0];
          end
          if (row_chg) begin
            chg_nxt = 1'b1;
          end
          if (t_r == last_row) begin
            lastnew_nxt = new_row;
          end
        end
        if (t_r == ROW_W'(MAX_ROWS - 1)) begin
          // End of a generation: set up the next one or stop
          gens_nxt = gens_r - GEN_W'(1);
          chg_nxt  = 1'b0;
          prev_nxt = (t_r == last_row) ? new_row : lastnew_r;
          if (gens_r == GEN_W'(1) || !(chg_r || row_chg)) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      t_r         <= '0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      t_r         <= t_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    gens_r     <= gens_nxt;
    kind_r     <= kind_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    lastnew_r  <= lastnew_nxt;
    res_cell_r <= res_cell_nxt;
    res_stat_r <= res_stat_nxt;
    out_cell_r <= out_cell_nxt;
    out_stat_r <= out_stat_nxt;
  end

  `LLA_ASSERT_NOW(a_gen_head_tracks_pass, state_r == ST_GEN, head_r == t_r, "ring head lost sync with generation pass")
  `LLA_ASSERT_NEXT(a_finish_loads_out, state_r == ST_FINISH && (!out_valid_r || out_chan.ready), out_valid_r && state_r == ST_IDLE, "finished result not presented")
  `LLA_ASSERT_NEXT(a_write_lands, state_r == ST_SEEK && head_r == row_r && kind_r == KIND_WRITE, row_q[0][$past(col_r)] == $past(val_r), "cell write did not land in head row")
  `LLA_ASSERT_NOW(a_busy_blocks_input, state_r != ST_IDLE, !in_chan.ready, "input accepted while an item is in work")
endmodule
`default_nettype wire
